// ===== src/ppt_pkg.sv =====
package ppt_pkg;

    // scaled tick amount: round(delta * time_scale / 256) always fits in 24 bits
    localparam int DELTA_W = 16;
    localparam int SCALE_W = 16;
    localparam int COUNT_W = 16;
    localparam int AMT_W   = 24;
    localparam int TIME_BITS_DEFAULT = 24;

    // command codes
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESUME  = 3'd3,
        OP_RESTART = 3'd4,
        OP_CANCEL  = 3'd5
    } opcode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_INITIAL_DELAY  = 3'd0,
        REG_PULSE_INTERVAL = 3'd1,
        REG_PULSE_COUNT    = 3'd2,
        REG_FINISH_DELAY   = 3'd3,
        REG_PULSE_ENABLE   = 3'd4,
        REG_FINISH_ENABLE  = 3'd5,
        REG_PROCESS_MODE   = 3'd6,
        REG_TIME_SCALE     = 3'd7
    } reg_index_t;

    // tick gating modes
    typedef enum logic [1:0] {
        PM_ALWAYS      = 2'd0,
        PM_PAUSABLE    = 2'd1,
        PM_WHEN_PAUSED = 2'd2,
        PM_DISABLED    = 2'd3
    } proc_mode_t;

    // timer phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_DELAY  = 4'b0010,
        PH_PULSE  = 4'b0100,
        PH_FINISH = 4'b1000
    } phase_t;

    // reset values of the narrow registers
    localparam logic [SCALE_W-1:0] TIME_SCALE_RESET = 16'd256;

    // control-side configuration shared by the input stage and the core
    typedef struct packed {
        logic [COUNT_W-1:0] pulse_total;
        logic               pulse_enable;
        logic               finish_enable;
        proc_mode_t         tick_mode;
        logic [SCALE_W-1:0] time_scale;
    } ctl_cfg_t;

    // one registered command
    typedef struct packed {
        logic [2:0]       opcode;
        logic [AMT_W-1:0] amount;
        logic             paused;
    } item_t;

    // one result
    typedef struct packed {
        logic               pulse_fired;
        logic [COUNT_W-1:0] pulse_number;
        logic               finish_fired;
        logic               done_res;
        logic               running;
        logic               warning;
    } result_t;

endpackage

// ===== src/ppt_cfg_regs.sv =====
module ppt_cfg_regs
    import ppt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    parameter int CFG_W = (TIME_BITS > COUNT_W) ? TIME_BITS : COUNT_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [TIME_BITS-1:0] initial_delay,
    output logic [TIME_BITS-1:0] pulse_period,
    output logic [TIME_BITS-1:0] finish_wait,
    output ctl_cfg_t             ctl
);

    logic [TIME_BITS-1:0] initial_delay_reg;
    logic [TIME_BITS-1:0] pulse_period_reg;
    logic [TIME_BITS-1:0] finish_wait_reg;
    ctl_cfg_t             ctl_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_delay_reg     <= '0;
            pulse_period_reg      <= TIME_BITS'(1);
            finish_wait_reg       <= '0;
            ctl_reg.pulse_total   <= '0;
            ctl_reg.pulse_enable  <= 1'b0;
            ctl_reg.finish_enable <= 1'b0;
            ctl_reg.tick_mode     <= PM_PAUSABLE;
            ctl_reg.time_scale    <= TIME_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INITIAL_DELAY:  initial_delay_reg     <= cfg_data[TIME_BITS-1:0];
                REG_PULSE_INTERVAL: pulse_period_reg      <= cfg_data[TIME_BITS-1:0];
                REG_PULSE_COUNT:    ctl_reg.pulse_total   <= cfg_data[COUNT_W-1:0];
                REG_FINISH_DELAY:   finish_wait_reg       <= cfg_data[TIME_BITS-1:0];
                REG_PULSE_ENABLE:   ctl_reg.pulse_enable  <= cfg_data[0];
                REG_FINISH_ENABLE:  ctl_reg.finish_enable <= cfg_data[0];
                REG_PROCESS_MODE:   ctl_reg.tick_mode     <= proc_mode_t'(cfg_data[1:0]);
                REG_TIME_SCALE:     ctl_reg.time_scale    <= cfg_data[SCALE_W-1:0];
                default:            ctl_reg               <= ctl_reg;
            endcase
        end
    end

    assign initial_delay = initial_delay_reg;
    assign pulse_period  = pulse_period_reg;
    assign finish_wait   = finish_wait_reg;
    assign ctl           = ctl_reg;

endmodule

// ===== src/ppt_in_stage.sv =====
module ppt_in_stage
    import ppt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [DELTA_W-1:0] delta,
    input  logic               paused,
    input  logic [SCALE_W-1:0] time_scale,
    input  logic               advance,
    output logic               item_valid,
    output item_t              item
);

    logic                       valid_reg;
    logic                       valid_next;
    item_t                      item_reg;
    logic [DELTA_W+SCALE_W-1:0] product;
    logic [DELTA_W+SCALE_W-1:0] rounded;
    logic                       take;

    // hold the item while the core cannot move it on
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    // scale the tick amount, round half up; the sum stays below 2^32
    assign product = DELTA_W'(delta) * SCALE_W'(time_scale);
    assign rounded = product + (DELTA_W+SCALE_W)'(128);

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.opcode <= opcode;
            item_reg.amount <= rounded[AMT_W+7:8];
            item_reg.paused <= paused;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/ppt_core.sv =====
module ppt_core
    import ppt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  item_t                item,
    input  logic                 advance,
    input  logic [TIME_BITS-1:0] initial_delay,
    input  logic [TIME_BITS-1:0] pulse_period,
    input  logic [TIME_BITS-1:0] finish_wait,
    input  ctl_cfg_t             ctl,
    output logic                 res_valid,
    output result_t              res
);

    // countdown width and the wider working width for subtract and carry
    localparam int TLW = TIME_BITS + 9;
    localparam int DW  = ((TLW > AMT_W + 1) ? TLW : AMT_W + 1) + 1;
    localparam longint TL_MIN_L = -(longint'(1) << (TIME_BITS + 8));
    localparam logic signed [DW-1:0] TL_MIN = DW'(TL_MIN_L);

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic signed [TLW-1:0]   tl_reg;
    logic signed [TLW-1:0]   tl_next;
    logic [COUNT_W-1:0]      pl_reg;
    logic [COUNT_W-1:0]      pl_next;
    logic                    started_reg;
    logic                    started_next;
    logic                    run_reg;
    logic                    run_next;

    logic                    fire;
    logic                    gate_ok;
    phase_t                  ph0;
    phase_t                  ph1;
    phase_t                  ph2;
    logic [TIME_BITS-1:0]    ld0;
    logic [TIME_BITS-1:0]    ld1;
    logic [TIME_BITS-1:0]    ld2;
    phase_t                  ph_w;
    logic signed [DW-1:0]    tl_w;
    logic signed [DW-1:0]    carry_w;
    logic                    go_w;
    result_t                 res_w;

    function automatic logic signed [DW-1:0] sat_low(input logic signed [DW-1:0] v);
        sat_low = (v < TL_MIN) ? TL_MIN : v;
    endfunction

    function automatic logic signed [DW-1:0] widen(input logic [TIME_BITS-1:0] v);
        widen = $signed({{(DW-TIME_BITS){1'b0}}, v});
    endfunction

    assign fire = item_valid && advance;

    // tick gating by the tick mode and the sampled pause flag
    always_comb
    begin
        unique case (ctl.tick_mode)
            PM_ALWAYS:      gate_ok = 1'b1;
            PM_PAUSABLE:    gate_ok = !item.paused;
            PM_WHEN_PAUSED: gate_ok = item.paused;
            PM_DISABLED:    gate_ok = 1'b0;
            default:        gate_ok = 1'b0;
        endcase
    end

    // next enabled phase and its load, from the top and after delay / pulse
    always_comb
    begin
        priority if (initial_delay != '0)
        begin
            ph0 = PH_DELAY;  ld0 = initial_delay;
        end
        else if (ctl.pulse_enable)
        begin
            ph0 = PH_PULSE;  ld0 = pulse_period;
        end
        else if (ctl.finish_enable)
        begin
            ph0 = PH_FINISH; ld0 = finish_wait;
        end
        else
        begin
            ph0 = PH_IDLE;   ld0 = '0;
        end

        priority if (ctl.pulse_enable)
        begin
            ph1 = PH_PULSE;  ld1 = pulse_period;
        end
        else if (ctl.finish_enable)
        begin
            ph1 = PH_FINISH; ld1 = finish_wait;
        end
        else
        begin
            ph1 = PH_IDLE;   ld1 = '0;
        end

        priority if (ctl.finish_enable)
        begin
            ph2 = PH_FINISH; ld2 = finish_wait;
        end
        else
        begin
            ph2 = PH_IDLE;   ld2 = '0;
        end
    end

    // command decode and the single-pass phase chain
    always_comb
    begin
        ph_w         = phase_reg;
        tl_w         = {{(DW-TLW){tl_reg[TLW-1]}}, tl_reg};
        carry_w      = $signed({{(DW-AMT_W){1'b0}}, item.amount});
        go_w         = 1'b1;
        pl_next      = pl_reg;
        started_next = started_reg;
        run_next     = run_reg;
        res_w        = '0;

        unique case (item.opcode)
            OP_TICK:
            begin
                if (run_reg && gate_ok)
                begin
                    // initial delay
                    if (ph_w == PH_DELAY)
                    begin
                        tl_w = sat_low(tl_w - carry_w);
                        if (tl_w > 0)
                            go_w = 1'b0;
                        else
                        begin
                            carry_w = -tl_w;
                            ph_w    = ph1;
                            tl_w    = widen(ld1);
                        end
                    end
                    // pulse phase, overshoot kept on reload
                    if (go_w && ph_w == PH_PULSE)
                    begin
                        tl_w = sat_low(tl_w - carry_w);
                        if (tl_w > 0)
                            go_w = 1'b0;
                        else
                        begin
                            if (pl_reg != '0)
                                pl_next = pl_reg - COUNT_W'(1);
                            res_w.pulse_fired  = 1'b1;
                            res_w.pulse_number = ctl.pulse_total - pl_next;
                            if (ctl.pulse_total != '0 && pl_next == '0)
                            begin
                                carry_w = -tl_w;
                                ph_w    = ph2;
                                tl_w    = widen(ld2);
                            end
                            else
                            begin
                                tl_w = tl_w + widen(pulse_period);
                                go_w = 1'b0;
                            end
                        end
                    end
                    // finish delay
                    if (go_w && ph_w == PH_FINISH)
                    begin
                        tl_w = sat_low(tl_w - carry_w);
                        if (tl_w > 0)
                            go_w = 1'b0;
                        else
                        begin
                            res_w.finish_fired = 1'b1;
                            ph_w               = PH_IDLE;
                        end
                    end
                    // nothing left: complete
                    if (go_w && ph_w == PH_IDLE)
                    begin
                        res_w.done_res = 1'b1;
                        ph_w           = PH_IDLE;
                        tl_w           = '0;
                        pl_next        = '0;
                        started_next   = 1'b0;
                        run_next       = 1'b0;
                    end
                end
            end
            OP_START, OP_RESTART:
            begin
                if (item.opcode == OP_START)
                    res_w.warning = started_reg || run_reg;
                else
                    res_w.warning = !started_reg;
                res_w.pulse_fired = ctl.pulse_enable;
                pl_next           = ctl.pulse_total;
                ph_w              = ph0;
                tl_w              = widen(ld0);
                started_next      = 1'b1;
                run_next          = 1'b1;
            end
            OP_PAUSE:
            begin
                res_w.warning = !started_reg || !run_reg;
                run_next      = 1'b0;
            end
            OP_RESUME:
            begin
                res_w.warning = !started_reg || run_reg;
                run_next      = 1'b1;
            end
            OP_CANCEL:
            begin
                res_w.warning = !started_reg;
                ph_w          = PH_IDLE;
                tl_w          = '0;
                pl_next       = '0;
                started_next  = 1'b0;
                run_next      = 1'b0;
            end
            default:
            begin
                res_w.warning = 1'b1;
            end
        endcase

        res_w.running = run_next;
        phase_next    = ph_w;
        tl_next       = tl_w[TLW-1:0];
    end

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tl_reg      <= '0;
            pl_reg      <= '0;
            started_reg <= 1'b0;
            run_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            tl_reg      <= tl_next;
            pl_reg      <= pl_next;
            started_reg <= started_next;
            run_reg     <= run_next;
        end
    end

    assign res_valid = fire;
    assign res       = res_w;

    // a timer that was never started sits in idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> phase_reg == PH_IDLE)
        else $error("phase active without start");

    // idle phase never keeps a countdown
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tl_reg == '0)
        else $error("countdown left over in idle");

    // completion clears run and start state
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_w.done_res |=> !run_reg && !started_reg && phase_reg == PH_IDLE)
        else $error("completion did not clear state");

    // a tick while stopped produces no events
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.opcode == OP_TICK && !run_reg |->
            !res_w.pulse_fired && !res_w.finish_fired && !res_w.done_res)
        else $error("event on a stopped timer");

endmodule

// ===== src/ppt_out_stage.sv =====
module ppt_out_stage
    import ppt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  result_t            res,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               pulse_fired,
    output logic [COUNT_W-1:0] pulse_number,
    output logic               finish_fired,
    output logic               done_res,
    output logic               running,
    output logic               warning
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // the core may move on when the result slot is free or being taken
    assign advance = !valid_reg || !out_stall;

    always_comb
    begin
        if (res_valid)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign out_valid    = valid_reg;
    assign pulse_fired  = res_reg.pulse_fired;
    assign pulse_number = res_reg.pulse_number;
    assign finish_fired = res_reg.finish_fired;
    assign done_res     = res_reg.done_res;
    assign running      = res_reg.running;
    assign warning      = res_reg.warning;

endmodule

// ===== src/phased_pulse_timer.sv =====
// Phased pulse timer: each transfer on the input channel is one command (tick,
// start, pause, resume, restart, cancel) and yields exactly one result transfer.
// A timer run walks an optional initial delay, periodic pulses (a set number of
// them, or without end when the count is zero) and an optional finish delay; a
// tick is gated by the tick mode register and the sampled pause flag and
// advances by round(delta * time_scale / 256). One command can be taken every
// clock cycle while in_stall is low; its result is presented on the output from
// the result register: the scaled amount is formed into the input register at
// the transfer, then the core updates the timer state and loads the result
// register. While a result waits under out_stall the core holds; one more
// command can still enter the input register, after which in_stall rises.
// Configuration writes are always ready and take effect for the next command;
// write them only while no command is in flight.
module phased_pulse_timer
    import ppt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    parameter int CFG_W = (TIME_BITS > COUNT_W) ? TIME_BITS : COUNT_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [DELTA_W-1:0] delta,
    input  logic               paused,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               pulse_fired,
    output logic [COUNT_W-1:0] pulse_number,
    output logic               finish_fired,
    output logic               done_res,
    output logic               running,
    output logic               warning,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic [TIME_BITS-1:0] initial_delay;
    logic [TIME_BITS-1:0] pulse_period;
    logic [TIME_BITS-1:0] finish_wait;
    ctl_cfg_t             ctl;
    logic                 advance;
    logic                 item_valid;
    item_t                item;
    logic                 res_valid;
    result_t              res;

    // configuration registers
    ppt_cfg_regs #(
        .TIME_BITS (TIME_BITS),
        .CFG_W     (CFG_W)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .initial_delay (initial_delay),
        .pulse_period  (pulse_period),
        .finish_wait   (finish_wait),
        .ctl           (ctl)
    );

    // input register with tick scaling
    ppt_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .delta      (delta),
        .paused     (paused),
        .time_scale (ctl.time_scale),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // timer state and phase logic
    ppt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .advance       (advance),
        .initial_delay (initial_delay),
        .pulse_period  (pulse_period),
        .finish_wait   (finish_wait),
        .ctl           (ctl),
        .res_valid     (res_valid),
        .res           (res)
    );

    // result register
    ppt_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pulse_fired  (pulse_fired),
        .pulse_number (pulse_number),
        .finish_fired (finish_fired),
        .done_res     (done_res),
        .running      (running),
        .warning      (warning)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    import ppt_pkg::*;

    localparam int TW = TIME_BITS_DEFAULT;
    // most negative value the signed countdown may hold
    localparam longint TL_FLOOR = -(longint'(1) <<< (TW + 8));
    // command codes the block does not define
    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    typedef struct {
        logic [TW-1:0]      initial_delay;
        logic [TW-1:0]      pulse_period;
        logic [COUNT_W-1:0] pulse_total;
        logic [TW-1:0]      finish_wait;
        logic               pulse_enable;
        logic               finish_enable;
        proc_mode_t         tick_mode;
        logic [SCALE_W-1:0] time_scale;
    } timer_cfg_t;

    // shadow copy of the timer channel and the results it still owes
    class timer_shadow;
        logic [TW-1:0]      initial_delay;
        logic [TW-1:0]      pulse_period;
        logic [COUNT_W-1:0] pulse_total;
        logic [TW-1:0]      finish_wait;
        logic               pulse_enable;
        logic               finish_enable;
        proc_mode_t         tick_mode;
        logic [SCALE_W-1:0] time_scale;

        phase_t              phase;
        logic signed [TW+8:0] time_left;
        logic [COUNT_W-1:0]  pulses_left;
        logic                started;
        logic                run_flag;

        result_t outcome_q[$];
        int      errors;

        function new();
            initial_delay  = '0;
            pulse_period   = TW'(1);
            pulse_total    = '0;
            finish_wait    = '0;
            pulse_enable   = 1'b0;
            finish_enable  = 1'b0;
            tick_mode      = PM_PAUSABLE;
            time_scale     = TIME_SCALE_RESET;
            errors         = 0;
            clear_run();
        endfunction

        function void clear_run();
            run_flag    = 1'b0;
            started     = 1'b0;
            phase       = PH_IDLE;
            time_left   = '0;
            pulses_left = '0;
        endfunction

        function void write_reg(reg_index_t idx, logic [TW-1:0] v);
            case (idx)
                REG_INITIAL_DELAY:  initial_delay  = v;
                REG_PULSE_INTERVAL: pulse_period   = v;
                REG_PULSE_COUNT:    pulse_total    = v[COUNT_W-1:0];
                REG_FINISH_DELAY:   finish_wait    = v;
                REG_PULSE_ENABLE:   pulse_enable   = v[0];
                REG_FINISH_ENABLE:  finish_enable  = v[0];
                REG_PROCESS_MODE:   tick_mode      = proc_mode_t'(v[1:0]);
                REG_TIME_SCALE:     time_scale     = v[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // register value as a countdown start
        function logic signed [TW+8:0] as_count(logic [TW-1:0] v);
            return $signed({{9{1'b0}}, v});
        endfunction

        // move to the first enabled phase after the given one
        function void enter_after(phase_t from);
            if (from == PH_IDLE && initial_delay != 0)
            begin
                phase     = PH_DELAY;
                time_left = as_count(initial_delay);
            end
            else if ((from == PH_IDLE || from == PH_DELAY) && pulse_enable)
            begin
                phase     = PH_PULSE;
                time_left = as_count(pulse_period);
            end
            else if (from != PH_FINISH && finish_enable)
            begin
                phase     = PH_FINISH;
                time_left = as_count(finish_wait);
            end
            else
            begin
                phase     = PH_IDLE;
                time_left = '0;
            end
        endfunction

        function longint floor_sat(longint v);
            return (v < TL_FLOOR) ? TL_FLOOR : v;
        endfunction

        function bit admits(logic p);
            case (tick_mode)
                PM_ALWAYS:      return 1'b1;
                PM_PAUSABLE:    return !p;
                PM_WHEN_PAUSED: return p;
                default:        return 1'b0;
            endcase
        endfunction

        function void begin_run(inout result_t r);
            if (pulse_enable)
            begin
                r.pulse_fired  = 1'b1;
                r.pulse_number = '0;
            end
            pulses_left = pulse_total;
            enter_after(PH_IDLE);
            started  = 1'b1;
            run_flag = 1'b1;
        endfunction

        // one tick: overshoot of an expired phase carries into the next one
        function void advance_timer(logic [DELTA_W-1:0] d, logic p, inout result_t r);
            longint amt;
            longint left;
            bit     go;
            if (!run_flag || !admits(p))
                return;
            amt = (longint'(d) * longint'(time_scale) + 128) >>> 8;
            go  = 1'b1;
            if (phase == PH_DELAY)
            begin
                left      = floor_sat(longint'(time_left) - amt);
                time_left = left[TW+8:0];
                if (left > 0)
                    go = 1'b0;
                else
                begin
                    amt = -left;
                    enter_after(PH_DELAY);
                end
            end
            if (go && phase == PH_PULSE)
            begin
                left = floor_sat(longint'(time_left) - amt);
                if (left > 0)
                begin
                    time_left = left[TW+8:0];
                    go        = 1'b0;
                end
                else
                begin
                    if (pulses_left != 0)
                        pulses_left--;
                    r.pulse_fired  = 1'b1;
                    r.pulse_number = pulse_total - pulses_left;
                    if (pulse_total != 0 && pulses_left == 0)
                    begin
                        amt = -left;
                        enter_after(PH_PULSE);
                    end
                    else
                    begin
                        left      = left + longint'(pulse_period);
                        time_left = left[TW+8:0];
                        go        = 1'b0;
                    end
                end
            end
            if (go && phase == PH_FINISH)
            begin
                left      = floor_sat(longint'(time_left) - amt);
                time_left = left[TW+8:0];
                if (left > 0)
                    go = 1'b0;
                else
                begin
                    r.finish_fired = 1'b1;
                    phase          = PH_IDLE;
                end
            end
            if (go && phase == PH_IDLE)
            begin
                r.done_res = 1'b1;
                clear_run();
            end
        endfunction

        function void note_command(logic [2:0] op, logic [DELTA_W-1:0] d, logic p);
            result_t r;
            r = '0;
            case (op)
                OP_TICK:
                    advance_timer(d, p, r);
                OP_START:
                begin
                    if (started || run_flag)
                        r.warning = 1'b1;
                    begin_run(r);
                end
                OP_PAUSE:
                begin
                    if (!started || !run_flag)
                        r.warning = 1'b1;
                    run_flag = 1'b0;
                end
                OP_RESUME:
                begin
                    if (!started || run_flag)
                        r.warning = 1'b1;
                    run_flag = 1'b1;
                end
                OP_RESTART:
                begin
                    if (!started)
                        r.warning = 1'b1;
                    clear_run();
                    begin_run(r);
                end
                OP_CANCEL:
                begin
                    if (!started)
                        r.warning = 1'b1;
                    clear_run();
                end
                default:
                    r.warning = 1'b1;
            endcase
            r.running = run_flag;
            outcome_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (outcome_q.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                errors++;
                return;
            end
            want = outcome_q.pop_front();
            compare_field("pulse_fired", 16'(want.pulse_fired), 16'(got.pulse_fired));
            compare_field("pulse_number", want.pulse_number, got.pulse_number);
            compare_field("finish_fired", 16'(want.finish_fired), 16'(got.finish_fired));
            compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
            compare_field("running", 16'(want.running), 16'(got.running));
            compare_field("warning", 16'(want.warning), 16'(got.warning));
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [2:0]         opcode    = '0;
    logic [DELTA_W-1:0] delta     = '0;
    logic               paused    = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               pulse_fired;
    logic [COUNT_W-1:0] pulse_number;
    logic               finish_fired;
    logic               done_res;
    logic               running;
    logic               warning;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [TW-1:0]      cfg_data  = '0;

    bit          quiet = 1'b0;
    timer_shadow shadow;

    phased_pulse_timer dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #(12 * 300000);
        $display("phased_pulse_timer: mismatch");
        $finish;
    end

    // result side back-pressure in bursts
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            out_stall <= 1'b0;
            repeat (n) @(posedge clk);
            if (!quiet)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            shadow.check_result({pulse_fired, pulse_number, finish_fired,
                                 done_res, running, warning});
    end

    task automatic idle_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // one command transfer, then maybe a gap
    task automatic issue(logic [2:0] op, logic [DELTA_W-1:0] d, logic p);
        in_valid <= 1'b1;
        opcode   <= op;
        delta    <= d;
        paused   <= p;
        do @(posedge clk); while (in_stall);
        shadow.note_command(op, d, p);
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_input($urandom_range(1, 7));
    endtask

    // hold off commands until every result is back and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_setting(timer_cfg_t s);
        logic [TW-1:0] vals [8];
        vals[REG_INITIAL_DELAY]  = s.initial_delay;
        vals[REG_PULSE_INTERVAL] = s.pulse_period;
        vals[REG_PULSE_COUNT]    = TW'(s.pulse_total);
        vals[REG_FINISH_DELAY]   = s.finish_wait;
        vals[REG_PULSE_ENABLE]   = TW'(s.pulse_enable);
        vals[REG_FINISH_ENABLE]  = TW'(s.finish_enable);
        vals[REG_PROCESS_MODE]   = TW'(s.tick_mode);
        vals[REG_TIME_SCALE]     = TW'(s.time_scale);
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            shadow.write_reg(reg_index_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic timer_cfg_t make_setting(logic [TW-1:0] dly, logic [TW-1:0] ivl,
                                                logic [COUNT_W-1:0] cnt, logic [TW-1:0] fin,
                                                logic pe, logic fe, proc_mode_t pm,
                                                logic [SCALE_W-1:0] sc);
        timer_cfg_t s;
        s.initial_delay  = dly;
        s.pulse_period   = ivl;
        s.pulse_total    = cnt;
        s.finish_wait    = fin;
        s.pulse_enable   = pe;
        s.finish_enable  = fe;
        s.tick_mode      = pm;
        s.time_scale     = sc;
        return s;
    endfunction

    // mostly short spans so that phases turn over often
    function automatic logic [TW-1:0] pick_span(bit nonzero);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return nonzero ? TW'(1) : TW'(0);
        if (r == 1)
            return '1;
        return TW'($urandom_range(nonzero ? 1 : 0, 40));
    endfunction

    function automatic timer_cfg_t random_setting(proc_mode_t pm);
        timer_cfg_t s;
        int         r;
        s.initial_delay  = pick_span(1'b0);
        s.pulse_period   = pick_span(1'b1);
        s.finish_wait    = pick_span(1'b0);
        r = $urandom_range(0, 9);
        s.pulse_total    = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF :
                           16'($urandom_range(1, 6));
        s.pulse_enable   = ($urandom_range(0, 4) != 0);
        s.finish_enable  = 1'($urandom_range(0, 1));
        s.tick_mode      = pm;
        r = $urandom_range(0, 9);
        s.time_scale     = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                           (r == 2) ? 16'($urandom_range(0, 65535)) :
                                      16'($urandom_range(128, 512));
        return s;
    endfunction

    // mostly ticks, with the odd control command and undefined code
    task automatic random_command(int paused_pct);
        int                 r;
        logic [2:0]         op;
        logic [DELTA_W-1:0] d;
        r = $urandom_range(0, 99);
        if (r < 78)
            op = OP_TICK;
        else if (r < 83)
            op = OP_START;
        else if (r < 87)
            op = OP_PAUSE;
        else if (r < 91)
            op = OP_RESUME;
        else if (r < 95)
            op = OP_RESTART;
        else if (r < 98)
            op = OP_CANCEL;
        else
            op = $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
        r = $urandom_range(0, 9);
        d = (r < 6) ? DELTA_W'($urandom_range(0, 8)) :
            (r < 9) ? DELTA_W'($urandom_range(0, 255)) :
                      DELTA_W'($urandom_range(0, 65535));
        issue(op, d, $urandom_range(0, 99) < paused_pct);
    endtask

    initial
    begin
        timer_cfg_t s;
        int         len;
        int         paused_pct;
        shadow = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: commands out of order, undefined codes, empty runs
        issue(OP_TICK, 16'd0, 1'b0);
        issue(OP_PAUSE, 16'd0, 1'b0);
        issue(OP_RESUME, 16'd0, 1'b0);
        issue(OP_TICK, 16'd1, 1'b0);
        issue(OP_BAD_LO, 16'hFFFF, 1'b1);
        issue(OP_BAD_HI, 16'd0, 1'b0);
        issue(OP_CANCEL, 16'd0, 1'b0);
        issue(OP_RESTART, 16'd0, 1'b0);
        issue(OP_START, 16'd0, 1'b0);
        issue(OP_TICK, 16'hFFFF, 1'b1);
        issue(OP_TICK, 16'hFFFF, 1'b0);
        drain();

        // overshoot through the delay, counted pulses, zero finish delay
        load_setting(make_setting(TW'(3), TW'(2), 16'd3, TW'(0), 1'b1, 1'b1,
                                  PM_ALWAYS, 16'hFFFF));
        issue(OP_START, 16'd0, 1'b0);
        issue(OP_TICK, 16'd0, 1'b0);
        issue(OP_TICK, 16'd1, 1'b0);
        issue(OP_TICK, 16'd0, 1'b0);
        issue(OP_TICK, 16'd0, 1'b0);
        issue(OP_PAUSE, 16'd0, 1'b0);
        issue(OP_RESUME, 16'd0, 1'b0);
        issue(OP_CANCEL, 16'd0, 1'b0);
        drain();

        // largest registers, zero scale, ticks only while paused
        load_setting(make_setting('1, '1, 16'hFFFF, '1, 1'b1, 1'b1, PM_WHEN_PAUSED, 16'd0));
        issue(OP_START, 16'd0, 1'b0);
        issue(OP_TICK, 16'hFFFF, 1'b1);
        issue(OP_TICK, 16'hFFFF, 1'b0);
        issue(OP_RESTART, 16'd0, 1'b0);
        issue(OP_PAUSE, 16'd0, 1'b0);
        issue(OP_RESUME, 16'd0, 1'b0);
        drain();

        // endless fast pulse train driven down to the countdown floor
        load_setting(make_setting(TW'(0), TW'(1), 16'd0, TW'(0), 1'b1, 1'b0,
                                  PM_ALWAYS, 16'hFFFF));
        issue(OP_START, 16'd0, 1'b0);
        repeat (300) issue(OP_TICK, 16'hFFFF, 1'b0);
        drain();

        // random settings, each run opened by a start
        for (int k = 0; k < 11; k++)
        begin
            if (k == 10)
                quiet = 1'b1;
            s = random_setting(proc_mode_t'(k % 4));
            load_setting(s);
            paused_pct = (s.tick_mode == PM_WHEN_PAUSED) ? 70 : 25;
            len        = (s.tick_mode == PM_DISABLED) ? 30 : 110;
            issue(OP_START, DELTA_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            repeat (len - 1) random_command(paused_pct);
            drain();
        end

        if (shadow.errors == 0)
            $display("phased_pulse_timer: match");
        else
            $display("phased_pulse_timer: mismatch");
        $finish;
    end

endmodule

// ===== phased_pulse_timer.f =====
src/ppt_pkg.sv
src/ppt_cfg_regs.sv
src/ppt_in_stage.sv
src/ppt_core.sv
src/ppt_out_stage.sv
src/phased_pulse_timer.sv
tb/tb.sv
